/* rtl/core/buddy_page_allocator_unit_defines.svh */
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BPA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_ALWAYS(lbl, cond)
`endif
`endif

/* rtl/core/bpa_pkg.sv */
// Types, constants and helper functions of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int PageCountDef = 1024;
  localparam int MaxOrderDef  = 5;
  localparam int WordW        = 32;
  localparam int WordBitW     = 5;
  localparam int InOrderW     = 3;
  localparam int InPageW      = 10;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;
  localparam logic StsDone  = 1'b0;
  localparam logic StsNoMem = 1'b1;

  typedef struct packed {
    logic                action;
    logic [InOrderW-1:0] block_order;
    logic [InPageW-1:0]  page_number;
  } bpa_req_t;

  typedef struct packed {
    logic               status;
    logic [InPageW-1:0] granted_page;
  } bpa_rsp_t;

  typedef enum logic [10:0] {
    StInit = 11'b000_0000_0001,
    StIdle = 11'b000_0000_0010,
    StSRd  = 11'b000_0000_0100,
    StSChk = 11'b000_0000_1000,
    StPRd  = 11'b000_0001_0000,
    StPWr  = 11'b000_0010_0000,
    StFRd  = 11'b000_0100_0000,
    StFChk = 11'b000_1000_0000,
    StMRd  = 11'b001_0000_0000,
    StMWr  = 11'b010_0000_0000,
    StDone = 11'b100_0000_0000
  } bpa_state_e;

  // Words of the map held by one order.
  function automatic int order_words(int pc, int k);
    return ((pc >> k) + WordW - 1) >> WordBitW;
  endfunction

  // First map word of order k.
  function automatic int map_base(int pc, int k);
    int s;
    s = 0;
    for (int j = 0; j < k; j++) s += order_words(pc, j);
    return s;
  endfunction

  // Reset contents of word w of the top order.
  function automatic logic [WordW-1:0] top_word(int pc, int mo, int w);
    int rem;
    rem = (pc >> mo) - (w << WordBitW);
    if (rem >= WordW) return '1;
    if (rem <= 0) return '0;
    return (WordW'(1) << rem) - WordW'(1);
  endfunction

endpackage

/* rtl/core/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/buddy_page_allocator_unit.sv */
// Top level of the buddy page allocator: map RAM, sequencer and result register.
//
//  channel | direction | signals                          | transfer when
//  --------+-----------+----------------------------------+----------------------
//  request | in        | in_valid_i, in_stall_o, in_req_i | in_valid_i & !in_stall_o
//  result  | out       | out_valid_o, out_stall_i, out_rsp_o | out_valid_o & !out_stall_i
//
// The free map sits in one RAM of 32-bit words, order by order; a map word is read first
// and written back only where it changes. Allocate: a read per word scanned (orders from
// the requested one upward), a write-back of the word that holds the free block, a read
// and a write-back per split level, then the result. Free: a read per buddy checked (one
// per order, stopping at the first busy buddy or the top order), a write-back of each
// free buddy taken, a read and a write-back for the final mark, then the result. After
// reset a clearing pass writes every map word once (one word a cycle) before the first
// request is taken. One request at a time; a finished result waits in the output register
// and the next request is taken meanwhile unless the previous result still blocks it.
`timescale 1ns / 1ps
`include "buddy_page_allocator_unit_defines.svh"
module buddy_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = PageCountDef,
  parameter int MAX_ORDER  = MaxOrderDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bpa_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bpa_rsp_t out_rsp_o
);
  localparam int Total = map_base(PAGE_COUNT, MAX_ORDER + 1);
  localparam int AW    = (Total > 1) ? $clog2(Total) : 1;
  localparam int PW    = $clog2(PAGE_COUNT);
  localparam int OW    = $clog2(MAX_ORDER + 2);
  localparam int KIW   = $clog2(MAX_ORDER + 1);

  logic [AW-1:0] base_tab [MAX_ORDER+1];
  logic [AW-1:0] last_tab [MAX_ORDER+1];

  always_comb begin
    for (int j = 0; j <= MAX_ORDER; j++) begin
      base_tab[j] = AW'(map_base(PAGE_COUNT, j));
      last_tab[j] = AW'(order_words(PAGE_COUNT, j) - 1);
    end
  end

  bpa_state_e     state_q, state_d;
  logic [OW-1:0]  k_q, k_d, ord_q, ord_d;
  logic [AW-1:0]  widx_q, widx_d, init_q, init_d;
  logic [PW-1:0]  page_q, page_d;
  logic           sts_q, sts_d;
  logic           out_valid_q, out_valid_d;
  bpa_rsp_t       out_q, out_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  bpa_ram #(.WIDTH(WordW), .DEPTH(Total)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Address generation: order table index clamped to the top order when k_q exceeds it.
  logic [KIW-1:0]   kidx;
  logic [PW-1:0]    blk, tblk;
  logic             flip;
  logic [AW-1:0]    scan_addr, blk_addr;
  logic [WordW-1:0] bmask, lowbit;
  logic [WordBitW-1:0] lowidx;
  logic [AW+WordBitW-1:0] hit_blk;
  logic [WordW-1:0] init_word;
  logic             in_acc;
  logic [31:0]      al_page, req_order;

  always_comb begin
    kidx      = (k_q > OW'(MAX_ORDER)) ? KIW'(MAX_ORDER) : KIW'(k_q);
    blk       = page_q >> k_q;
    flip      = (state_q == StPRd) || (state_q == StPWr) ||
                (state_q == StFRd) || (state_q == StFChk);
    tblk      = blk ^ PW'(flip);
    scan_addr = base_tab[kidx] + widx_q;
    blk_addr  = base_tab[kidx] + AW'(tblk >> WordBitW);
    bmask     = WordW'(1) << tblk[WordBitW-1:0];
    lowbit    = ram_rdata & (~ram_rdata + WordW'(1));
    lowidx    = '0;
    for (int b = 0; b < WordW; b++) begin
      if (lowbit[b]) lowidx = lowidx | WordBitW'(b);
    end
    hit_blk   = {widx_q, lowidx};
    if (init_q >= base_tab[MAX_ORDER]) begin
      init_word = top_word(PAGE_COUNT, MAX_ORDER, int'(init_q - base_tab[MAX_ORDER]));
    end else begin
      init_word = '0;
    end
    req_order = 32'(in_req_i.block_order);
    al_page   = 32'(in_req_i.page_number) & ~((32'd1 << req_order) - 32'd1);
  end

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    ord_d       = ord_q;
    widx_d      = widx_q;
    init_d      = init_q;
    page_d      = page_q;
    sts_d       = sts_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = blk_addr;
    ram_wdata   = ram_rdata | bmask;
    ram_raddr   = (state_q == StSRd) ? scan_addr : blk_addr;
    case (state_q)
      StInit: begin
        // Sweep the map: top order gets its full blocks, the rest clears.
        ram_we    = 1'b1;
        ram_waddr = init_q;
        ram_wdata = init_word;
        init_d    = init_q + AW'(1);
        if (init_q == AW'(Total - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_acc) begin
          sts_d  = StsDone;
          page_d = '0;
          k_d    = OW'(in_req_i.block_order);
          ord_d  = OW'(in_req_i.block_order);
          widx_d = '0;
          if (req_order > 32'(MAX_ORDER)) begin
            sts_d   = (in_req_i.action == ActAlloc) ? StsNoMem : StsDone;
            state_d = StDone;
          end else if (in_req_i.action == ActAlloc) begin
            state_d = StSRd;
          end else if ((al_page >> req_order) >= (32'(PAGE_COUNT) >> req_order)) begin
            state_d = StDone;
          end else begin
            page_d  = PW'(al_page);
            state_d = (req_order == 32'(MAX_ORDER)) ? StMRd : StFRd;
          end
        end
      end
      StSRd: state_d = StSChk;
      StSChk: begin
        if (|ram_rdata) begin
          // Take the lowest free block of this order.
          ram_we    = 1'b1;
          ram_waddr = scan_addr;
          ram_wdata = ram_rdata & ~lowbit;
          page_d    = PW'(32'(hit_blk) << k_q);
          if (k_q > ord_q) begin
            k_d     = k_q - OW'(1);
            state_d = StPRd;
          end else begin
            state_d = StDone;
          end
        end else if (widx_q == last_tab[kidx]) begin
          widx_d = '0;
          if (k_q == OW'(MAX_ORDER)) begin
            sts_d   = StsNoMem;
            page_d  = '0;
            state_d = StDone;
          end else begin
            k_d     = k_q + OW'(1);
            state_d = StSRd;
          end
        end else begin
          widx_d  = widx_q + AW'(1);
          state_d = StSRd;
        end
      end
      StPRd: state_d = StPWr;
      StPWr: begin
        // Upper half goes free at this order.
        ram_we = 1'b1;
        if (k_q > ord_q) begin
          k_d     = k_q - OW'(1);
          state_d = StPRd;
        end else begin
          state_d = StDone;
        end
      end
      StFRd: state_d = StFChk;
      StFChk: begin
        if ((ram_rdata & bmask) != '0) begin
          // Buddy free: drop it and climb one order.
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~bmask;
          page_d    = page_q & ~(PW'(1) << k_q);
          k_d       = k_q + OW'(1);
          state_d   = (k_q + OW'(1) == OW'(MAX_ORDER)) ? StMRd : StFRd;
        end else begin
          state_d = StMRd;
        end
      end
      StMRd: state_d = StMWr;
      StMWr: begin
        ram_we  = 1'b1;
        page_d  = '0;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = sts_q;
          out_d.granted_page = InPageW'(page_q);
          state_d            = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    ord_q  <= ord_d;
    widx_q <= widx_d;
    page_q <= page_d;
    sts_q  <= sts_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `BPA_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q))
  `BPA_ASSERT_IMP(a_scan_order_range, state_q == StSChk, k_q <= OW'(MAX_ORDER))
  `BPA_ASSERT_IMP(a_split_above_req, state_q == StPWr, k_q >= ord_q)
  `BPA_ASSERT_IMP(a_take_when_idle, in_acc, state_q == StIdle)

endmodule
